// File: sv/qera_pkg.sv
// ----------------------------------------------------------------------------
// qera_pkg
// shared types and constants of the quad edge rotation angle unit
// ----------------------------------------------------------------------------
package qera_pkg;

    // normalized edge magnitudes and flags
    typedef struct packed {
        logic [14:0] mx;
        logic [14:0] my;
        logic        negx;
        logic        negy;
        logic        zero;
    } t_edge;

    localparam int UNIT_LAT  = 36;
    localparam int MAX_ITERS = 24;
    localparam int UNIT_MAX  = 32767;

    localparam logic signed [26:0] ACC_180 = 27'sd11796480;
    localparam logic signed [26:0] ACC_360 = 27'sd23592960;
    localparam logic [16:0]        ANG_FULL = 17'd46080;

    // atan(2^-i) in degrees * 65536
    function automatic logic [22:0] atan_q16(input int i);
        logic [22:0] t;
        unique case (i)
            0:  t = 23'd2949120;
            1:  t = 23'd1740967;
            2:  t = 23'd919879;
            3:  t = 23'd466945;
            4:  t = 23'd234379;
            5:  t = 23'd117304;
            6:  t = 23'd58666;
            7:  t = 23'd29335;
            8:  t = 23'd14668;
            9:  t = 23'd7334;
            10: t = 23'd3667;
            11: t = 23'd1833;
            12: t = 23'd917;
            13: t = 23'd458;
            14: t = 23'd229;
            15: t = 23'd115;
            16: t = 23'd57;
            17: t = 23'd29;
            18: t = 23'd14;
            19: t = 23'd7;
            20: t = 23'd4;
            21: t = 23'd2;
            22: t = 23'd1;
            default: t = 23'd0;
        endcase
        return t;
    endfunction

endpackage

// File: sv/qera_norm.sv
// ----------------------------------------------------------------------------
// qera_norm
// forms the edges of the quadrilateral from the start corner and normalizes their magnitudes
// ----------------------------------------------------------------------------
module qera_norm #(
    parameter int COORD_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_ce,
    input  logic                      i_valid,
    input  logic [1:0]                i_start,
    input  logic [4*COORD_BITS-1:0]   i_cx,
    input  logic [4*COORD_BITS-1:0]   i_cy,
    output logic                      o_valid,
    output qera_pkg::t_edge [3:0]     o_edge
);
    import qera_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int DW = CB + 1;
    localparam int WW = (CB > 15) ? CB : 15;
    localparam int PW = ($clog2(CB) > 4) ? $clog2(CB) : 4;

    logic [2:0]              r_v;
    logic signed [DW-1:0]    r_dx [4];
    logic signed [DW-1:0]    r_dy [4];
    logic signed [DW-1:0]    n_dx [4];
    logic signed [DW-1:0]    n_dy [4];
    logic [CB-1:0]           r_mx [4];
    logic [CB-1:0]           r_my [4];
    logic [CB-1:0]           r_max [4];
    logic                    r_nx [4];
    logic                    r_ny [4];
    t_edge [3:0]             r_e;
    t_edge [3:0]             n_e;

    always_comb begin
        logic [1:0] a;
        logic [1:0] b;
        for (int k = 0; k < 4; k++) begin
            a = i_start + 2'(k);
            b = a + 2'd1;
            n_dx[k] = $signed({i_cx[b*CB + CB - 1], i_cx[b*CB +: CB]})
                    - $signed({i_cx[a*CB + CB - 1], i_cx[a*CB +: CB]});
            n_dy[k] = $signed({i_cy[b*CB + CB - 1], i_cy[b*CB +: CB]})
                    - $signed({i_cy[a*CB + CB - 1], i_cy[a*CB +: CB]});
        end
    end

    always_comb begin
        logic [PW-1:0] p;
        logic [WW-1:0] wx;
        logic [WW-1:0] wy;
        for (int k = 0; k < 4; k++) begin
            p = '0;
            for (int j = 0; j < CB; j++) begin
                if (r_max[k][j]) begin
                    p = PW'(j);
                end
            end
            wx = WW'(r_mx[k]);
            wy = WW'(r_my[k]);
            if (p >= PW'(14)) begin
                wx = wx >> (p - PW'(14));
                wy = wy >> (p - PW'(14));
            end else begin
                wx = wx << (PW'(14) - p);
                wy = wy << (PW'(14) - p);
            end
            n_e[k].mx   = wx[14:0];
            n_e[k].my   = wy[14:0];
            n_e[k].negx = r_nx[k];
            n_e[k].negy = r_ny[k];
            n_e[k].zero = (r_max[k] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ce) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        logic [DW-1:0] ax;
        logic [DW-1:0] ay;
        if (i_ce) begin
            for (int k = 0; k < 4; k++) begin
                r_dx[k]  <= n_dx[k];
                r_dy[k]  <= n_dy[k];
                ax       = r_dx[k][DW-1] ? DW'(-r_dx[k]) : DW'(r_dx[k]);
                ay       = r_dy[k][DW-1] ? DW'(-r_dy[k]) : DW'(r_dy[k]);
                r_mx[k]  <= ax[CB-1:0];
                r_my[k]  <= ay[CB-1:0];
                r_max[k] <= (ax > ay) ? ax[CB-1:0] : ay[CB-1:0];
                r_nx[k]  <= r_dx[k][DW-1];
                r_ny[k]  <= r_dy[k][DW-1];
            end
            r_e <= n_e;
        end
    end

    assign o_valid = r_v[2];
    assign o_edge  = r_e;

endmodule

// File: sv/qera_unit.sv
// ----------------------------------------------------------------------------
// qera_unit
// unit vector of one edge: squared length, pipelined square root and divide
// ----------------------------------------------------------------------------
module qera_unit (
    input  logic                i_clk,
    input  logic                i_ce,
    input  qera_pkg::t_edge     i_edge,
    output logic signed [15:0]  o_ux,
    output logic signed [15:0]  o_uy
);
    import qera_pkg::*;

    localparam int SQ_STEPS  = 16;
    localparam int DIV_STEPS = 17;

    logic [31:0] r_sq;
    t_edge       r_me;
    logic [31:0] r_sv [SQ_STEPS];
    logic [31:0] r_sr [SQ_STEPS];
    t_edge       r_se [SQ_STEPS];

    logic [15:0] r_len;
    logic [30:0] r_dxd;
    logic [30:0] r_dyd;
    t_edge       r_pe;

    logic [15:0] r_rx [DIV_STEPS];
    logic [15:0] r_ry [DIV_STEPS];
    logic [16:0] r_qx [DIV_STEPS];
    logic [16:0] r_qy [DIV_STEPS];
    logic [15:0] r_dl [DIV_STEPS];
    logic [30:0] r_ddx [DIV_STEPS];
    logic [30:0] r_ddy [DIV_STEPS];
    t_edge       r_de [DIV_STEPS];

    logic signed [15:0] r_ux;
    logic signed [15:0] r_uy;

    function automatic logic [63:0] sqrt_step(input logic [31:0] v, input logic [31:0] r,
                                              input int k);
        logic [31:0] b;
        logic [31:0] t;
        logic [31:0] nv;
        logic [31:0] nr;
        b = 32'd1 << (30 - 2 * k);
        t = r + b;
        if (v >= t) begin
            nv = v - t;
            nr = (r >> 1) + b;
        end else begin
            nv = v;
            nr = r >> 1;
        end
        return {nv, nr};
    endfunction

    function automatic logic [16:0] div_step(input logic [15:0] rem, input logic d,
                                             input logic [15:0] len);
        logic [16:0] t;
        logic        q;
        t = {rem, d};
        q = (t >= {1'b0, len});
        if (q) begin
            t = t - {1'b0, len};
        end
        return {t[15:0], q};
    endfunction

    function automatic logic signed [15:0] fin(input logic [16:0] q, input logic neg);
        logic [15:0] m;
        m = (q > 17'(UNIT_MAX)) ? 16'(UNIT_MAX) : q[15:0];
        return neg ? -$signed(m) : $signed(m);
    endfunction

    always_ff @(posedge i_clk) begin
        logic [63:0] s;
        logic [16:0] dx;
        logic [16:0] dy;
        if (i_ce) begin
            r_sq <= 32'({i_edge.mx} * {i_edge.mx}) + 32'({i_edge.my} * {i_edge.my});
            r_me <= i_edge;

            s = sqrt_step(r_sq, 32'd0, 0);
            r_sv[0] <= s[63:32];
            r_sr[0] <= s[31:0];
            r_se[0] <= r_me;
            for (int k = 1; k < SQ_STEPS; k++) begin
                s = sqrt_step(r_sv[k-1], r_sr[k-1], k);
                r_sv[k] <= s[63:32];
                r_sr[k] <= s[31:0];
                r_se[k] <= r_se[k-1];
            end

            r_len <= r_sr[SQ_STEPS-1][15:0];
            r_dxd <= {1'b0, r_se[SQ_STEPS-1].mx, 15'd0} + 31'(r_sr[SQ_STEPS-1][15:1]);
            r_dyd <= {1'b0, r_se[SQ_STEPS-1].my, 15'd0} + 31'(r_sr[SQ_STEPS-1][15:1]);
            r_pe  <= r_se[SQ_STEPS-1];

            dx = div_step({2'd0, r_dxd[30:17]}, r_dxd[16], r_len);
            dy = div_step({2'd0, r_dyd[30:17]}, r_dyd[16], r_len);
            r_rx[0]  <= dx[16:1];
            r_ry[0]  <= dy[16:1];
            r_qx[0]  <= {16'd0, dx[0]};
            r_qy[0]  <= {16'd0, dy[0]};
            r_dl[0]  <= r_len;
            r_ddx[0] <= r_dxd;
            r_ddy[0] <= r_dyd;
            r_de[0]  <= r_pe;
            for (int j = 1; j < DIV_STEPS; j++) begin
                dx = div_step(r_rx[j-1], r_ddx[j-1][16-j], r_dl[j-1]);
                dy = div_step(r_ry[j-1], r_ddy[j-1][16-j], r_dl[j-1]);
                r_rx[j]  <= dx[16:1];
                r_ry[j]  <= dy[16:1];
                r_qx[j]  <= {r_qx[j-1][15:0], dx[0]};
                r_qy[j]  <= {r_qy[j-1][15:0], dy[0]};
                r_dl[j]  <= r_dl[j-1];
                r_ddx[j] <= r_ddx[j-1];
                r_ddy[j] <= r_ddy[j-1];
                r_de[j]  <= r_de[j-1];
            end

            if (r_de[DIV_STEPS-1].zero) begin
                r_ux <= 16'sd32767;
                r_uy <= 16'sd0;
            end else begin
                r_ux <= fin(r_qx[DIV_STEPS-1], r_de[DIV_STEPS-1].negx);
                r_uy <= fin(r_qy[DIV_STEPS-1], r_de[DIV_STEPS-1].negy);
            end
        end
    end

    assign o_ux = r_ux;
    assign o_uy = r_uy;

endmodule

// File: sv/qera_cordic.sv
// ----------------------------------------------------------------------------
// qera_cordic
// rotates and sums the unit vectors, pipelined cordic vectoring to degrees
// ----------------------------------------------------------------------------
module qera_cordic #(
    parameter int CORDIC_ITERS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_ce,
    input  logic                i_valid,
    input  logic [3:0][15:0]    i_ux,
    input  logic [3:0][15:0]    i_uy,
    output logic                o_valid,
    output logic [15:0]         o_angle
);
    import qera_pkg::*;

    localparam int N = (CORDIC_ITERS > MAX_ITERS) ? MAX_ITERS : CORDIC_ITERS;
    localparam int XW = 34;

    logic [N+2:0]             r_v;
    logic signed [18:0]       r_sx;
    logic signed [18:0]       r_sy;
    logic signed [XW-1:0]     r_x [N+1];
    logic signed [XW-1:0]     r_y [N+1];
    logic signed [26:0]       r_a [N+1];
    logic                     r_z [N+1];
    logic [15:0]              r_ang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ce) begin
            r_v <= {r_v[N+1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic signed [26:0]   t;
        logic signed [26:0]   a;
        logic [16:0]          q;
        if (i_ce) begin
            r_sx <= 19'(signed'(i_ux[0])) - 19'(signed'(i_uy[1]))
                  - 19'(signed'(i_ux[2])) + 19'(signed'(i_uy[3]));
            r_sy <= 19'(signed'(i_uy[0])) + 19'(signed'(i_ux[1]))
                  - 19'(signed'(i_uy[2])) - 19'(signed'(i_ux[3]));

            x = XW'(r_sx) <<< 12;
            y = XW'(r_sy) <<< 12;
            r_z[0] <= (r_sx == '0) && (r_sy == '0);
            if (r_sx < 0) begin
                r_x[0] <= -x;
                r_y[0] <= -y;
                r_a[0] <= ACC_180;
            end else begin
                r_x[0] <= x;
                r_y[0] <= y;
                r_a[0] <= '0;
            end

            for (int i = 0; i < N; i++) begin
                xs = r_x[i] >>> i;
                ys = r_y[i] >>> i;
                t  = $signed({4'd0, atan_q16(i)});
                r_z[i+1] <= r_z[i];
                if (!r_y[i][XW-1]) begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_a[i+1] <= r_a[i] + t;
                end else begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_a[i+1] <= r_a[i] - t;
                end
            end

            a = r_a[N][26] ? r_a[N] + ACC_360 : r_a[N];
            a = a + 27'sd256;
            q = a[25:9];
            if (q >= ANG_FULL) begin
                q = q - ANG_FULL;
            end
            r_ang <= r_z[N] ? 16'd0 : q[15:0];
        end
    end

    assign o_valid = r_v[N+2];
    assign o_angle = r_ang;

endmodule

// File: sv/quad_edge_rotation_angle_unit.sv
// ----------------------------------------------------------------------------
// quad_edge_rotation_angle_unit
// circular mean of the edge directions of a quadrilateral, in 1/128 deg
// ----------------------------------------------------------------------------
// pipeline: the normalize stages, then the square root and divide stages of each
//   edge lane, then the cordic stages
// throughput: one transaction per cycle; a stalled output holds the whole pipe
// reset: synchronous, clears only the valid bits, no clearing pass
// ----------------------------------------------------------------------------
module quad_edge_rotation_angle_unit #(
    parameter int COORD_BITS   = 16,
    parameter int CORDIC_ITERS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // start_corner, corner0_x, corner0_y, ... corner3_x, corner3_y, zero pad
    input  logic [((2 + 8*COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // angle_deg_q7
    output logic [15:0]                             m_tdata
);
    import qera_pkg::*;

    localparam int CB = COORD_BITS;

    logic                ce;
    logic [4*CB-1:0]     cx;
    logic [4*CB-1:0]     cy;
    logic                nrm_valid;
    t_edge [3:0]         edges;
    logic [UNIT_LAT-1:0] r_uv;
    logic [3:0][15:0]    ux;
    logic [3:0][15:0]    uy;

    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            cx[k*CB +: CB] = s_tdata[2 + 2*k*CB +: CB];
            cy[k*CB +: CB] = s_tdata[2 + (2*k+1)*CB +: CB];
        end
    end

    qera_norm #(.COORD_BITS(COORD_BITS)) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (s_tvalid),
        .i_start (s_tdata[1:0]),
        .i_cx    (cx),
        .i_cy    (cy),
        .o_valid (nrm_valid),
        .o_edge  (edges)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uv <= '0;
        end else if (ce) begin
            r_uv <= {r_uv[UNIT_LAT-2:0], nrm_valid};
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_lane
        qera_unit u_unit (
            .i_clk  (i_clk),
            .i_ce   (ce),
            .i_edge (edges[k]),
            .o_ux   (ux[k]),
            .o_uy   (uy[k])
        );
    end

    qera_cordic #(.CORDIC_ITERS(CORDIC_ITERS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (r_uv[UNIT_LAT-1]),
        .i_ux    (ux),
        .i_uy    (uy),
        .o_valid (m_tvalid),
        .o_angle (m_tdata)
    );

endmodule

// File: sv/qera_check.sv
// ----------------------------------------------------------------------------
// qera_check
// port level checks of the quad edge rotation angle unit
// ----------------------------------------------------------------------------
module qera_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    import qera_pkg::*;

    // a waiting result holds its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // angle stays below a full turn
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> ({1'b0, m_tdata} < ANG_FULL))
        else $error("angle out of range");

    // nothing comes out right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    // input side only stalls when a result is waiting
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

endmodule

bind quad_edge_rotation_angle_unit qera_check u_qera_check (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
